FILE: rtl/core/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and the 5x7 font table of the text rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

   localparam int GTR_SCREEN_WIDTH  = 128;
   localparam int GTR_SCREEN_HEIGHT = 128;
   localparam int GTR_MAX_SCALE     = 4;

   // mask width and row count bound the scale to four
   localparam int GTR_SCALE_HW   = 4;
   localparam int GTR_MASK_W     = 20;
   localparam int GTR_GLYPH_ROWS = 7;

   localparam logic [7:0] GTR_CODE_FIRST = 8'h20;
   localparam logic [7:0] GTR_CODE_LAST  = 8'h7E;

   // controller to datapath
   typedef struct packed {
      logic       load;  // item accepted
      logic       emit;  // write one row span into the output register
      logic       last;  // this span is the final one of the character
      logic [4:0] row;   // span index within the character
      logic [2:0] grow;  // font row of this span
   } gtr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       stall; // output register full and not taken
      logic [2:0] scale; // latched scale
   } gtr_sts_type;

   function automatic logic signed [11:0] gtr_sat12(input logic signed [12:0] v);
      logic signed [11:0] r;
      if (v > 13'sd2047) begin
         r = 12'sh7FF;
      end else if (v < -13'sd2048) begin
         r = 12'sh800;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

   // column 0 in the top byte, bit 0 of each byte is the top font row
   function automatic logic [39:0] gtr_glyph(input logic [6:0] idx);
      logic [39:0] g;
      case (idx)
         7'd0:  g = 40'h0000000000;
         7'd1:  g = 40'h00005F0000;
         7'd2:  g = 40'h0007000700;
         7'd3:  g = 40'h147F147F14;
         7'd4:  g = 40'h242A7F2A12;
         7'd5:  g = 40'h2313086462;
         7'd6:  g = 40'h3649552250;
         7'd7:  g = 40'h0005030000;
         7'd8:  g = 40'h001C224100;
         7'd9:  g = 40'h0041221C00;
         7'd10: g = 40'h082A1C2A08;
         7'd11: g = 40'h08083E0808;
         7'd12: g = 40'h0050300000;
         7'd13: g = 40'h0808080808;
         7'd14: g = 40'h0060600000;
         7'd15: g = 40'h2010080402;
         7'd16: g = 40'h3E5149453E;
         7'd17: g = 40'h00427F4000;
         7'd18: g = 40'h4261514946;
         7'd19: g = 40'h2141454B31;
         7'd20: g = 40'h1814127F10;
         7'd21: g = 40'h2745454539;
         7'd22: g = 40'h3C4A494930;
         7'd23: g = 40'h0171090503;
         7'd24: g = 40'h3649494936;
         7'd25: g = 40'h064949291E;
         7'd26: g = 40'h0036360000;
         7'd27: g = 40'h0056360000;
         7'd28: g = 40'h0008142241;
         7'd29: g = 40'h1414141414;
         7'd30: g = 40'h4122140800;
         7'd31: g = 40'h0201510906;
         7'd32: g = 40'h324979413E;
         7'd33: g = 40'h7E1111117E;
         7'd34: g = 40'h7F49494936;
         7'd35: g = 40'h3E41414122;
         7'd36: g = 40'h7F4141221C;
         7'd37: g = 40'h7F49494941;
         7'd38: g = 40'h7F09090101;
         7'd39: g = 40'h3E41415132;
         7'd40: g = 40'h7F0808087F;
         7'd41: g = 40'h00417F4100;
         7'd42: g = 40'h2040413F01;
         7'd43: g = 40'h7F08142241;
         7'd44: g = 40'h7F40404040;
         7'd45: g = 40'h7F0204027F;
         7'd46: g = 40'h7F0408107F;
         7'd47: g = 40'h3E4141413E;
         7'd48: g = 40'h7F09090906;
         7'd49: g = 40'h3E4151215E;
         7'd50: g = 40'h7F09192946;
         7'd51: g = 40'h4649494931;
         7'd52: g = 40'h01017F0101;
         7'd53: g = 40'h3F4040403F;
         7'd54: g = 40'h1F2040201F;
         7'd55: g = 40'h7F2018207F;
         7'd56: g = 40'h6314081463;
         7'd57: g = 40'h0304780403;
         7'd58: g = 40'h6151494543;
         7'd59: g = 40'h00007F4141;
         7'd60: g = 40'h0204081020;
         7'd61: g = 40'h41417F0000;
         7'd62: g = 40'h0402010204;
         7'd63: g = 40'h4040404040;
         7'd64: g = 40'h0001020400;
         7'd65: g = 40'h2054545478;
         7'd66: g = 40'h7F48444438;
         7'd67: g = 40'h3844444420;
         7'd68: g = 40'h384444487F;
         7'd69: g = 40'h3854545418;
         7'd70: g = 40'h087E090102;
         7'd71: g = 40'h081454543C;
         7'd72: g = 40'h7F08040478;
         7'd73: g = 40'h00447D4000;
         7'd74: g = 40'h2040443D00;
         7'd75: g = 40'h007F102844;
         7'd76: g = 40'h00417F4000;
         7'd77: g = 40'h7C04180478;
         7'd78: g = 40'h7C08040478;
         7'd79: g = 40'h3844444438;
         7'd80: g = 40'h7C14141408;
         7'd81: g = 40'h081414187C;
         7'd82: g = 40'h7C08040408;
         7'd83: g = 40'h4854545420;
         7'd84: g = 40'h043F444020;
         7'd85: g = 40'h3C4040207C;
         7'd86: g = 40'h1C2040201C;
         7'd87: g = 40'h3C4030403C;
         7'd88: g = 40'h4428102844;
         7'd89: g = 40'h0C5050503C;
         7'd90: g = 40'h4464544C44;
         7'd91: g = 40'h0008364100;
         7'd92: g = 40'h00007F0000;
         7'd93: g = 40'h0041360800;
         7'd94: g = 40'h08082A1C08;
         default: g = 40'h0000000000;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gtr_ctrl.sv
// ----------------------------------------------------------------------------
// gtr_ctrl
// Row sequencer: takes one item, then steps through 7*scale row spans.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  gtr_pkg::gtr_sts_type sts,
   output gtr_pkg::gtr_cmd_type cmd
);
   import gtr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic       state_ff, state_in;
   logic [4:0] row_ff, row_in;
   logic [2:0] grow_ff, grow_in;
   logic [1:0] sub_ff, sub_in;
   logic       sub_end;
   logic       grow_end;

   assign req_tready = (state_ff == ST_IDLE);

   // sub counts the repeats of one font row
   assign sub_end  = (3'({1'b0, sub_ff}) + 3'd1) == sts.scale;
   assign grow_end = (grow_ff == 3'(GTR_GLYPH_ROWS - 1));

   always_comb begin
      cmd.load = req_tvalid && req_tready;
      cmd.emit = (state_ff == ST_RUN) && !sts.stall;
      cmd.last = sub_end && grow_end;
      cmd.row  = row_ff;
      cmd.grow = grow_ff;
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      grow_in  = grow_ff;
      sub_in   = sub_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in  = '0;
            grow_in = '0;
            sub_in  = '0;
            if (cmd.load) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.emit) begin
               row_in = row_ff + 5'd1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end else if (sub_end) begin
                  sub_in  = '0;
                  grow_in = grow_ff + 3'd1;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         grow_ff  <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         grow_ff  <= grow_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/gtr_dp.sv
// ----------------------------------------------------------------------------
// gtr_dp
// Pen state, glyph latch, span mask builder and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_dp #(
   parameter int SCREEN_WIDTH  = gtr_pkg::GTR_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = gtr_pkg::GTR_SCREEN_HEIGHT,
   parameter int MAX_SCALE     = gtr_pkg::GTR_MAX_SCALE
) (
   input  wire                  clock,
   input  wire                  reset,
   input  gtr_pkg::gtr_cmd_type cmd,
   output gtr_pkg::gtr_sts_type sts,
   input  wire                  first_char,
   input  wire                  centered,
   input  wire  [5:0]           string_length,
   input  wire  signed [11:0]   start_x,
   input  wire  signed [11:0]   start_y,
   input  wire  [7:0]           char_code,
   input  wire  [15:0]          text_color,
   input  wire  [2:0]           glyph_scale,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic signed [11:0]   row_y,
   output logic signed [11:0]   row_x,
   output logic [19:0]          row_mask,
   output logic [15:0]          pixel_color,
   output logic                 last_row
);
   import gtr_pkg::*;

   localparam int SCALE_LIM = (MAX_SCALE < GTR_SCALE_HW) ? MAX_SCALE : GTR_SCALE_HW;
   localparam logic signed [12:0] SW13 = 13'(SCREEN_WIDTH);
   localparam logic signed [12:0] SH13 = 13'(SCREEN_HEIGHT);

   logic signed [11:0] pen_x_ff, pen_x_in;
   logic signed [11:0] pen_y_ff, pen_y_in;
   logic [15:0]        color_ff, color_in;
   logic [2:0]         scale_ff, scale_in;
   logic [39:0]        glyph_ff;
   logic               valid_ff, valid_in;
   logic signed [11:0] oy_ff, ox_ff;
   logic [19:0]        omask_ff;
   logic [15:0]        ocolor_ff;
   logic               olast_ff;

   logic [2:0]         sc;
   logic [7:0]         len_sc;
   logic [10:0]        span;
   logic signed [12:0] diff;
   logic signed [12:0] half;
   logic [6:0]         idx;

   logic [4:0]         bits;
   logic [19:0]        wide;
   logic [19:0]        xin;
   logic signed [12:0] y13;
   logic               yin;
   logic signed [12:0] adv;

   assign sts.stall = valid_ff && !rsp_ready;
   assign sts.scale = scale_ff;

   // scale clamp and centring
   always_comb begin
      if (glyph_scale == 3'd0) begin
         sc = 3'd1;
      end else if (glyph_scale > 3'(SCALE_LIM)) begin
         sc = 3'(SCALE_LIM);
      end else begin
         sc = glyph_scale;
      end
      len_sc = 8'({2'b00, string_length} * {3'b000, sc});
      // six columns per character, less the trailing gap, which may leave it negative
      span   = 11'({len_sc, 2'b00}) + 11'({len_sc, 1'b0});
      diff   = SW13 - $signed({2'b00, span}) + $signed({10'b0, sc});
      // halve, rounding toward zero
      half   = (diff + $signed({12'b0, diff[12]})) >>> 1;
      if (char_code >= GTR_CODE_FIRST && char_code <= GTR_CODE_LAST) begin
         idx = 7'(char_code - GTR_CODE_FIRST);
      end else begin
         idx = '0;
      end
   end

   // one row span
   always_comb begin
      for (int c = 0; c < 5; c++) begin
         bits[c] = glyph_ff[8 * (4 - c) + cmd.grow];
      end
      wide = '0;
      case (scale_ff)
         3'd1: begin
            for (int c = 0; c < 5; c++) begin
               wide[c] = bits[c];
            end
         end
         3'd2: begin
            for (int c = 0; c < 5; c++) begin
               wide[2*c]   = bits[c];
               wide[2*c+1] = bits[c];
            end
         end
         3'd3: begin
            for (int c = 0; c < 5; c++) begin
               wide[3*c]   = bits[c];
               wide[3*c+1] = bits[c];
               wide[3*c+2] = bits[c];
            end
         end
         default: begin
            for (int c = 0; c < 5; c++) begin
               wide[4*c]   = bits[c];
               wide[4*c+1] = bits[c];
               wide[4*c+2] = bits[c];
               wide[4*c+3] = bits[c];
            end
         end
      endcase
      for (int k = 0; k < GTR_MASK_W; k++) begin
         xin[k] = (13'(pen_x_ff) + 13'(k) >= 13'sd0) && (13'(pen_x_ff) + 13'(k) < SW13);
      end
      y13 = 13'(pen_y_ff) + $signed({8'b0, cmd.row});
      yin = (y13 >= 13'sd0) && (y13 < SH13);
      adv = 13'(pen_x_ff) + $signed({7'b0, 3'd0, scale_ff} * 13'sd6);
   end

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      color_in = color_ff;
      scale_in = scale_ff;
      if (cmd.load && first_char) begin
         scale_in = sc;
         color_in = text_color;
         pen_y_in = start_y;
         pen_x_in = centered ? gtr_sat12(half) : start_x;
      end else if (cmd.emit && cmd.last) begin
         pen_x_in = gtr_sat12(adv);
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         color_ff <= '0;
         scale_ff <= 3'd1;
         valid_ff <= 1'b0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         color_ff <= color_in;
         scale_ff <= scale_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         glyph_ff <= gtr_glyph(idx);
      end
      if (cmd.emit) begin
         oy_ff     <= gtr_sat12(y13);
         ox_ff     <= pen_x_ff;
         omask_ff  <= yin ? (wide & xin) : '0;
         ocolor_ff <= color_ff;
         olast_ff  <= cmd.last;
      end
   end

   assign rsp_valid   = valid_ff;
   assign row_y       = oy_ff;
   assign row_x       = ox_ff;
   assign row_mask    = omask_ff;
   assign pixel_color = ocolor_ff;
   assign last_row    = olast_ff;

endmodule

`default_nettype wire

FILE: rtl/core/glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_text_rasterizer
// Scaled 5x7 bitmap font text rasteriser, one row span per output item.
// ----------------------------------------------------------------------------
// Each input item is one character; it comes out as 7*scale row spans, top row
// first, each carrying the pen x, the frame row, a 20-bit pixel mask clipped
// to the frame and the colour, with tlast on the final span. When a character
// is taken, the glyph from the font table and the pen are latched; then the
// row sequencer gives one span per cycle while the output side keeps taking.
// The next character is taken while the last span still waits in the output
// register. A first character of a string latches pen, colour and scale;
// codes outside 0x20..0x7E draw as blanks.
`default_nettype none

module glyph_text_rasterizer #(
   parameter int SCREEN_WIDTH  = gtr_pkg::GTR_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = gtr_pkg::GTR_SCREEN_HEIGHT,
   parameter int MAX_SCALE     = gtr_pkg::GTR_MAX_SCALE
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // string_length[5:0], start_x[17:6], start_y[29:18], char_code[37:30],
   // text_color[53:38], glyph_scale[56:54], zero[63:57]
   input  wire  [63:0] req_tdata,
   // first_char[0], centered[1]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // row_y[11:0], row_x[23:12], row_mask[43:24], pixel_color[59:44], zero[63:60]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast
);
   import gtr_pkg::*;

   gtr_cmd_type        cmd;
   gtr_sts_type        sts;
   logic signed [11:0] row_y, row_x;
   logic [19:0]        row_mask;
   logic [15:0]        pixel_color;

   gtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gtr_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_SCALE     (MAX_SCALE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .first_char    (req_tuser[0]),
      .centered      (req_tuser[1]),
      .string_length (req_tdata[5:0]),
      .start_x       (req_tdata[17:6]),
      .start_y       (req_tdata[29:18]),
      .char_code     (req_tdata[37:30]),
      .text_color    (req_tdata[53:38]),
      .glyph_scale   (req_tdata[56:54]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .row_y         (row_y),
      .row_x         (row_x),
      .row_mask      (row_mask),
      .pixel_color   (pixel_color),
      .last_row      (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, pixel_color, row_mask, row_x, row_y};

endmodule

`default_nettype wire

FILE: rtl/core/gtr_checker.sv
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks on the rasteriser's request and span channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire        rsp_tlast,
   input wire [63:0] rsp_tdata
);

   // a stalled span holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("span changed while stalled");

   // every item yields at least one span, so no item is taken straight after one
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken again before its spans");

   // a new item never starts in the middle of a character
   a_no_take_mid_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request ready before the final span");

   // the first span of a newly taken item cannot appear in the cycle after the take
   a_span_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("span appeared without a load cycle");

endmodule

bind glyph_text_rasterizer gtr_checker u_gtr_checker (.*);

`default_nettype wire

FILE: sim/glyph_text_rasterizer_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer_chk
// Watches both streams of the text rasteriser. It works out every row span of
// each accepted character from its own pen state and font table, and compares
// the spans field by field as they leave the block.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer_chk (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   // string_length[5:0], start_x[17:6], start_y[29:18], char_code[37:30],
   // text_color[53:38], glyph_scale[56:54], zero[63:57]
   input  wire [63:0] req_tdata,
   // first_char[0], centered[1]
   input  wire [1:0]  req_tuser,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   // row_y[11:0], row_x[23:12], row_mask[43:24], pixel_color[59:44], zero[63:60]
   input  wire [63:0] rsp_tdata,
   input  wire        rsp_tlast,
   output int         fail_count,
   output int         spans_pending
);

   localparam int FRAME_W = gtr_pkg::GTR_SCREEN_WIDTH;
   localparam int FRAME_H = gtr_pkg::GTR_SCREEN_HEIGHT;
   // the 20-bit mask and 28 spans per character hold the scale to four
   localparam int SCALE_CAP = (gtr_pkg::GTR_MAX_SCALE < 4) ? gtr_pkg::GTR_MAX_SCALE : 4;
   localparam int MAX_REPORTS = 100;

   typedef struct {
      logic signed [11:0] row_y;
      logic signed [11:0] row_x;
      logic [19:0]        row_mask;
      logic [15:0]        pixel_color;
      logic               last_row;
   } row_span_type;

   row_span_type       spans_due[$];
   logic [39:0]        glyph_bits [0:94];
   logic signed [11:0] pen_x;
   logic signed [11:0] pen_y;
   logic [15:0]        pen_color;
   int                 pen_scale;
   int                 spans_seen;

   // column 0 in the top byte, bit 0 of a column is the top font row
   initial begin
      glyph_bits = '{
         40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
         40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
         40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
         40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
         40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
         40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
         40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
         40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
         40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
         40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
         40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
         40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
         40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
         40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
         40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
         40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
         40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
         40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
         40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
         40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
         40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
         40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
         40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
         40'h00007F0000, 40'h0041360800, 40'h08082A1C08
      };
   end

   function automatic logic signed [11:0] clamp12(input int v);
      if (v > 2047) return 12'sh7FF;
      if (v < -2048) return 12'sh800;
      return v[11:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [19:0] got,
                                  input logic [19:0] want);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t ns: span %0d %s: got 0x%0h, want 0x%0h",
                  $time, spans_seen, what, got, want);
      end
   endtask

   // updates the pen for one character and queues all of its spans
   task automatic rasterise_char(input logic [1:0] flags, input logic [63:0] word);
      logic [7:0]   code;
      logic [39:0]  glyph;
      logic [7:0]   column;
      logic [19:0]  mask;
      row_span_type span;
      int           sc;
      int           total;
      int           r;
      int           k;
      int           y;
      int           x;
      code = word[37:30];
      if (flags[0]) begin
         sc = int'(word[56:54]);
         if (sc < 1) sc = 1;
         if (sc > SCALE_CAP) sc = SCALE_CAP;
         pen_scale = sc;
         pen_color = word[53:38];
         pen_y     = word[29:18];
         if (flags[1]) begin
            total = int'(word[5:0]) * 6 * sc - sc;
            // int division truncates toward zero
            pen_x = clamp12((FRAME_W - total) / 2);
         end else begin
            pen_x = word[17:6];
         end
      end
      if (code >= gtr_pkg::GTR_CODE_FIRST && code <= gtr_pkg::GTR_CODE_LAST) begin
         glyph = glyph_bits[7'(code - gtr_pkg::GTR_CODE_FIRST)];
      end else begin
         glyph = glyph_bits[0];
      end
      for (r = 0; r < 7 * pen_scale; r++) begin
         y    = pen_y + r;
         mask = '0;
         for (k = 0; k < 5 * pen_scale; k++) begin
            x      = pen_x + k;
            column = glyph[39 - 8 * (k / pen_scale) -: 8];
            if (y >= 0 && y < FRAME_H && x >= 0 && x < FRAME_W && column[r / pen_scale]) begin
               mask[k] = 1'b1;
            end
         end
         span.row_y       = clamp12(y);
         span.row_x       = pen_x;
         span.row_mask    = mask;
         span.pixel_color = pen_color;
         span.last_row    = (r == 7 * pen_scale - 1);
         spans_due.push_back(span);
      end
      pen_x = clamp12(pen_x + 6 * pen_scale);
   endtask

   always @(posedge clock) begin : watch
      row_span_type want;
      if (reset) begin
         spans_due.delete();
         pen_x         = '0;
         pen_y         = '0;
         pen_color     = '0;
         pen_scale     = 1;
         fail_count    = 0;
         spans_seen    = 0;
         spans_pending = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rasterise_char(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (spans_due.size() == 0) begin
               report_mismatch("span with nothing due, mask", rsp_tdata[43:24], '0);
            end else begin
               want = spans_due.pop_front();
               if (rsp_tdata[11:0] !== want.row_y) begin
                  report_mismatch("row_y", {8'b0, rsp_tdata[11:0]},
                                  {8'b0, want.row_y});
               end
               if (rsp_tdata[23:12] !== want.row_x) begin
                  report_mismatch("row_x", {8'b0, rsp_tdata[23:12]},
                                  {8'b0, want.row_x});
               end
               if (rsp_tdata[43:24] !== want.row_mask) begin
                  report_mismatch("row_mask", rsp_tdata[43:24], want.row_mask);
               end
               if (rsp_tdata[59:44] !== want.pixel_color) begin
                  report_mismatch("pixel_color", {4'b0, rsp_tdata[59:44]},
                                  {4'b0, want.pixel_color});
               end
               if (rsp_tlast !== want.last_row) begin
                  report_mismatch("last_row", {19'b0, rsp_tlast}, {19'b0, want.last_row});
               end
            end
            spans_seen++;
         end
         spans_pending = spans_due.size();
      end
   end

endmodule

FILE: sim/glyph_text_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer_tb
// Drives characters into the text rasteriser: a directed run over the corner
// cases of placement, scale, clipping and codes, then random strings with
// random gaps and output stalls. The checker beside the block judges spans.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer_tb;

   localparam int RANDOM_CHARS    = 76;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 64;
   localparam int CYCLE_LIMIT     = 800000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          spans_pending;
   int          cycle_count;
   bit          rsp_hold_req  = 1'b0;
   int          req_gap_pct   = 0;
   int          rsp_stall_pct = 0;

   glyph_text_rasterizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   glyph_text_rasterizer_chk u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .spans_pending (spans_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [11:0] random_coord();
      int v;
      if ($urandom_range(0, 3) == 0) return 12'($urandom);
      v = $urandom_range(0, 170);
      return 12'(v - 30);
   endfunction

   function automatic logic [7:0] random_code();
      if ($urandom_range(0, 19) < 17) return 8'($urandom_range(32'h20, 32'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat (gap_cycles() - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic pause_req();
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles()) @(negedge clock);
      end
   endtask

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_char(input bit first_char, input bit centered,
                            input logic [5:0] string_length,
                            input logic [11:0] start_x, input logic [11:0] start_y,
                            input logic [7:0] char_code, input logic [15:0] text_color,
                            input logic [2:0] glyph_scale);
      pause_req();
      req_tvalid <= 1'b1;
      req_tuser  <= {centered, first_char};
      req_tdata  <= {7'd0, glyph_scale, text_color, char_code, start_y, start_x,
                     string_length};
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   // later characters carry junk in the fields that only a first char latches
   task automatic send_follow(input logic [7:0] char_code);
      send_char(1'b0, 1'($urandom_range(0, 1)), 6'($urandom), 12'($urandom),
                12'($urandom), char_code, 16'($urandom), 3'($urandom));
   endtask

   task automatic send_random_string(input int n_chars);
      bit          opener;
      bit          centered;
      logic [5:0]  string_length;
      logic [2:0]  glyph_scale;
      opener   = ($urandom_range(0, 9) != 0);
      centered = ($urandom_range(0, 9) < 3);
      if ($urandom_range(0, 3) == 0) string_length = 6'($urandom_range(0, 63));
      else string_length = 6'($urandom_range(0, 8));
      if ($urandom_range(0, 4) == 0) glyph_scale = 3'($urandom_range(0, 7));
      else glyph_scale = 3'($urandom_range(1, 4));
      send_char(opener, centered, string_length, random_coord(), random_coord(),
                random_code(), 16'($urandom), glyph_scale);
      for (int i = 1; i < n_chars; i++) begin
         send_follow(random_code());
      end
   endtask

   task automatic wait_spans_out();
      req_tvalid <= 1'b0;
      while (spans_pending != 0) @(negedge clock);
   endtask

   initial begin
      int random_chars;
      int string_no;
      int n_chars;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      // no first char yet: pen, colour and scale from reset
      send_follow(8'h41);
      send_char(1'b1, 1'b0, 6'd0, 12'd0, 12'd0, 8'h20, 16'hFFFF, 3'd1);
      send_follow(8'h7E);
      // codes outside the font draw blank
      send_follow(8'h1F);
      send_follow(8'h7F);
      send_follow(8'hFF);
      send_follow(8'h00);
      // scale 0 taken as 1, most negative pen
      send_char(1'b1, 1'b0, 6'd63, 12'h800, 12'h800, 8'h23, 16'h0000, 3'd0);
      // scale above the cap, most positive pen, advance saturates
      send_char(1'b1, 1'b0, 6'd0, 12'h7FF, 12'h7FF, 8'h7E, 16'hA5A5, 3'd7);
      send_follow(8'h4D);
      // clipped at the left and top edges
      send_char(1'b1, 1'b0, 6'd0, -12'sd3, -12'sd5, 8'h40, 16'h5A5A, 3'd4);
      send_follow(8'h57);
      // clipped at the right edge
      send_char(1'b1, 1'b0, 6'd0, 12'd110, 12'd100, 8'h57, 16'hF800, 3'd5);
      send_char(1'b1, 1'b0, 6'd0, 12'd2040, 12'd10, 8'h41, 16'h07E0, 3'd4);
      send_follow(8'h42);
      // centred placement ignores start_x; odd totals truncate toward zero
      send_char(1'b1, 1'b1, 6'd0, 12'd1234, 12'd20, 8'h48, 16'h1234, 3'd1);
      send_char(1'b1, 1'b1, 6'd63, 12'hFFF, 12'd30, 8'h69, 16'h4321, 3'd3);
      send_char(1'b1, 1'b1, 6'd63, 12'd0, 12'd40, 8'h6A, 16'hFFFF, 3'd4);
      send_char(1'b1, 1'b1, 6'd1, 12'hFFF, 12'd50, 8'h38, 16'h8001, 3'd2);
      send_char(1'b1, 1'b1, 6'd5, 12'd0, 12'd60, 8'h6F, 16'h7FFE, 3'd1);
      send_follow(8'h6B);
      send_char(1'b1, 1'b0, 6'd0, 12'd60, 12'd120, 8'h67, 16'h001F, 3'd2);
      send_char(1'b1, 1'b0, 6'd0, 12'd0, 12'd0, 8'h51, 16'hC0DE, 3'd3);

      random_chars = 0;
      string_no    = 0;
      while (random_chars < RANDOM_CHARS) begin
         case ((string_no / 4) % 3)
            0: begin
               req_gap_pct   = 20;
               rsp_stall_pct = 25;
            end
            1: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            default: begin
               req_gap_pct   = 50;
               rsp_stall_pct = 45;
            end
         endcase
         if (string_no == 5) begin
            // receiver holds off while the sender keeps offering
            rsp_hold_req = 1'b1;
            req_gap_pct  = 0;
            n_chars      = 8;
         end else begin
            n_chars = $urandom_range(1, 6);
         end
         if (string_no == 12) begin
            wait_spans_out();
         end
         send_random_string(n_chars);
         random_chars += n_chars;
         string_no++;
      end

      wait_spans_out();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && spans_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/gtr_pkg.sv
rtl/core/gtr_ctrl.sv
rtl/core/gtr_dp.sv
rtl/core/glyph_text_rasterizer.sv
rtl/core/gtr_checker.sv
sim/glyph_text_rasterizer_chk.sv
sim/glyph_text_rasterizer_tb.sv
